### sv/mids_pkg.sv
// Shared types and constants for the mesh index decode and sort block.
// Used by every module of the block; depends on nothing else.
package mids_pkg;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WIDE_CODES        = 2'd0;
   localparam logic [1:0] CSR_COMPRESSED_CODES  = 2'd1;
   localparam logic [1:0] CSR_NORTH_SOUTH_ORDER = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD_VERTEX = 2'd0,
      CMD_PUSH_CODE   = 2'd1,
      CMD_SORT        = 2'd2,
      CMD_NONE        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_VERTEX = 2'd0,
      OP_INDEX  = 2'd1,
      OP_SORT   = 2'd2
   } op_kind_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_LOAD_RD,
      B_LOAD_VX,
      B_LOAD_WR,
      B_SCAN_RD,
      B_SCAN_CMP,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         vertex_addr;
      logic signed [15:0] vertex_u;
      logic signed [15:0] vertex_v;
      logic [31:0]        code_word;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_index;
      logic               last;
      logic               bad_index;
      logic               overflowed;
   } rsp_type;

   // One classified command travelling from front to back.
   typedef struct packed {
      op_kind_type        kind;
      logic [9:0]         addr;
      logic signed [15:0] u;
      logic signed [15:0] v;
      logic [31:0]        idx;
      logic               ovf;
   } op_type;

   // One entry of the sort buffer.
   typedef struct packed {
      logic [31:0]        idx;
      logic signed [15:0] key_a;
      logic signed [15:0] key_b;
      logic               bad;
   } sort_entry_type;

endpackage

### sv/mids_front.sv
// Front part: accepts commands, decodes index codes and classifies each beat.
// Depends on mids_pkg; feeds mids_queue.
module mids_front import mids_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_INDICES  = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  logic    wide_codes,
   input  logic    compressed_codes,
   output logic    push,
   output op_type  op
);

   localparam int CNT_W = $clog2(MAX_INDICES + 1);

   logic [31:0]      hw_ff, hw_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [31:0]      code;

   // Code word as seen in the current width mode.
   assign code = wide_codes ? req.code_word : {16'b0, req.code_word[15:0]};

   // Classify the beat and track the run state.
   always_comb begin
      hw_in  = hw_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      push   = 1'b0;
      op     = '0;
      op.addr = req.vertex_addr;
      op.u    = req.vertex_u;
      op.v    = req.vertex_v;
      op.ovf  = ovf_ff;
      if (compressed_codes) begin
         op.idx = hw_ff - code;
      end else begin
         op.idx = wide_codes ? req.code_word : {{16{req.code_word[15]}}, req.code_word[15:0]};
      end
      if (accept) begin
         unique case (cmd_type'(req.cmd))
            CMD_LOAD_VERTEX: begin
               op.kind = OP_VERTEX;
               push = (32'(req.vertex_addr) < 32'(MAX_VERTICES));
            end
            CMD_PUSH_CODE: begin
               op.kind = OP_INDEX;
               if (cnt_ff < CNT_W'(MAX_INDICES)) begin
                  push   = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  if (compressed_codes && code == 32'd0) begin
                     hw_in = hw_ff + 32'd1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_SORT: begin
               op.kind = OP_SORT;
               push   = 1'b1;
               hw_in  = '0;
               cnt_in = '0;
               ovf_in = 1'b0;
            end
            CMD_NONE: begin
               op.kind = OP_SORT;
            end
            default: begin
               op.kind = OP_SORT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         hw_ff  <= hw_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

### sv/mids_queue.sv
// Short first-in first-out queue of classified commands.
// Depends on mids_pkg; sits between mids_front and mids_back.
module mids_queue import mids_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head,
   output logic   empty,
   output logic   full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   op_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = wr_ff + PTR_W'(push);
      rd_in  = rd_ff + PTR_W'(pop);
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_op;
      end
   end

endmodule

### sv/mids_back.sv
// Back part: vertex table, index store and the stable selection sort.
// Depends on mids_pkg; drains mids_queue and drives the result beats.
module mids_back import mids_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_INDICES  = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  op_type  head,
   input  logic    empty,
   input  logic    north_south_order,
   output logic    pop,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   localparam int VA_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int IX_W  = (MAX_INDICES > 1) ? $clog2(MAX_INDICES) : 1;
   localparam int CNT_W = $clog2(MAX_INDICES + 1);

   back_state_type state_ff, state_in;

   logic signed [15:0] vtx_u_mem [MAX_VERTICES];
   logic signed [15:0] vtx_v_mem [MAX_VERTICES];
   logic [31:0]        idx_mem   [MAX_INDICES];
   sort_entry_type     srt_mem   [MAX_INDICES];

   logic [31:0]          idx_q;
   logic signed [15:0]   u_q, v_q;
   sort_entry_type       srt_q, best_ff, wr_entry;
   logic [CNT_W-1:0]     cnt_ff, em_ff;
   logic [IX_W-1:0]      ptr_ff, scan_ff, best_pos_ff;
   logic                 found_ff, ovf_ff;
   logic [MAX_INDICES-1:0] used_ff;
   logic                 bad, take, scan_end;

   // Entry built from the fetched index and its vertex.
   assign bad = (idx_q >= 32'(MAX_VERTICES));
   always_comb begin
      wr_entry.idx   = idx_q;
      wr_entry.bad   = bad;
      wr_entry.key_a = bad ? 16'sd0 : (north_south_order ? u_q : v_q);
      wr_entry.key_b = bad ? 16'sd0 : (north_south_order ? v_q : u_q);
   end

   // Candidate wins on a strictly smaller key, so equal keys keep arrival order.
   assign take = !used_ff[scan_ff] && (!found_ff || (srt_q.key_a < best_ff.key_a) ||
                 ((srt_q.key_a == best_ff.key_a) && (srt_q.key_b < best_ff.key_b)));
   assign scan_end = ({1'b0, scan_ff} == (IX_W+1)'(cnt_ff - 1'b1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty && head.kind == OP_SORT) begin
               state_in = (cnt_ff == '0) ? B_IDLE : B_LOAD_RD;
            end
         end
         B_LOAD_RD:  state_in = B_LOAD_VX;
         B_LOAD_VX:  state_in = B_LOAD_WR;
         B_LOAD_WR: begin
            state_in = ({1'b0, ptr_ff} == (IX_W+1)'(cnt_ff - 1'b1)) ? B_SCAN_RD : B_LOAD_RD;
         end
         B_SCAN_RD:  state_in = B_SCAN_CMP;
         B_SCAN_CMP: state_in = scan_end ? B_EMIT : B_SCAN_RD;
         B_EMIT:     state_in = (em_ff == cnt_ff - 1'b1) ? B_IDLE : B_SCAN_RD;
         default:    state_in = B_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      pop              = (state_ff == B_IDLE) && !empty;
      rsp_strobe       = (state_ff == B_EMIT);
      rsp.sorted_index = best_ff.idx;
      rsp.bad_index    = best_ff.bad;
      rsp.overflowed   = ovf_ff;
      rsp.last         = (em_ff == cnt_ff - 1'b1);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff   <= '0;
         em_ff    <= '0;
         used_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            B_IDLE: begin
               if (pop && head.kind == OP_INDEX) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               em_ff    <= '0;
               found_ff <= 1'b0;
            end
            B_SCAN_CMP: begin
               if (take) begin
                  found_ff <= 1'b1;
               end
            end
            B_EMIT: begin
               found_ff <= 1'b0;
               if (em_ff == cnt_ff - 1'b1) begin
                  cnt_ff  <= '0;
                  used_ff <= '0;
               end else begin
                  em_ff <= em_ff + 1'b1;
                  used_ff[best_pos_ff] <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            ptr_ff  <= '0;
            scan_ff <= '0;
            if (pop) ovf_ff <= head.ovf;
         end
         B_LOAD_WR: begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         B_SCAN_CMP: begin
            if (take) begin
               best_ff     <= srt_q;
               best_pos_ff <= scan_ff;
            end
            scan_ff <= scan_end ? '0 : scan_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Vertex table: written by load beats, read by index during the sort load.
   always_ff @(posedge clock) begin
      if (pop && head.kind == OP_VERTEX) begin
         vtx_u_mem[VA_W'(head.addr)] <= head.u;
         vtx_v_mem[VA_W'(head.addr)] <= head.v;
      end
      u_q <= vtx_u_mem[idx_q[VA_W-1:0]];
      v_q <= vtx_v_mem[idx_q[VA_W-1:0]];
   end

   // Index store.
   always_ff @(posedge clock) begin
      if (pop && head.kind == OP_INDEX) begin
         idx_mem[cnt_ff[IX_W-1:0]] <= head.idx;
      end
      idx_q <= idx_mem[ptr_ff];
   end

   // Sort buffer.
   always_ff @(posedge clock) begin
      if (state_ff == B_LOAD_WR) begin
         srt_mem[ptr_ff] <= wr_entry;
      end
      srt_q <= srt_mem[scan_ff];
   end

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result beats on adjacent cycles");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.last) |=> (state_ff == B_IDLE && cnt_ff == '0))
      else $error("run not cleared after last beat");
   a_used_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE) |-> (used_ff == '0)) else $error("stale used marks");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_INDICES)) else $error("index count beyond store");

endmodule

### sv/mesh_index_decode_and_sort_core.sv
// Top level of the mesh index decode and sort block.
// Depends on mids_pkg, mids_front, mids_queue and mids_back.
//
// Vertex loads and code pushes are taken one per cycle while busy is low, and
// are decoded on entry; a four-deep command queue separates decoding from
// execution. A sort first fetches the keys of each stored index in turn and
// then runs a selection sort that scans the sort buffer once per result, one
// entry at a time through its read port; results appear on rsp_strobe and
// cannot be held off. busy is high while the queue is full, which happens
// only when commands pile up behind a sort.
module mesh_index_decode_and_sort_core import mids_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_INDICES  = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_wdata
);

   logic   wide_ff, comp_ff, ns_ff;
   logic   accept, push, pop, empty, full;
   op_type push_op, head;

   assign busy   = full;
   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b0;
         comp_ff <= 1'b0;
         ns_ff   <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == CSR_WIDE_CODES)        wide_ff <= csr_wdata[0];
         if (csr_index == CSR_COMPRESSED_CODES)  comp_ff <= csr_wdata[0];
         if (csr_index == CSR_NORTH_SOUTH_ORDER) ns_ff   <= csr_wdata[0];
      end
   end

   mids_front #(.MAX_VERTICES(MAX_VERTICES), .MAX_INDICES(MAX_INDICES)) u_front (
      .clock, .reset, .accept, .req(req_data),
      .wide_codes(wide_ff), .compressed_codes(comp_ff),
      .push, .op(push_op)
   );

   mids_queue u_queue (
      .clock, .reset, .push, .push_op, .pop, .head, .empty, .full
   );

   mids_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_INDICES(MAX_INDICES)) u_back (
      .clock, .reset, .head, .empty, .north_south_order(ns_ff),
      .pop, .rsp_strobe, .rsp(rsp_data)
   );

endmodule

### dv/tb_mesh_index_decode_and_sort_core.sv
// Self-checking testbench for mesh_index_decode_and_sort_core.
// Depends on mids_pkg and the RTL of the block; predicts every sorted beat
// from its own model of vertex table, index store and high-water decoding.
module tb_mesh_index_decode_and_sort_core import mids_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NVERT = 1024;
   localparam int NIDX = 64;
   localparam int VFILL = 96;
   localparam int WATCHDOG_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_WIDE_CODES;
   logic [0:0] csr_wdata = 1'b0;

   mesh_index_decode_and_sort_core dut (.*);

   always #4 clock = ~clock;

   // Predictor state.
   logic signed [15:0] tab_u [NVERT];
   logic signed [15:0] tab_v [NVERT];
   logic [31:0] stored_idx [$];
   logic [31:0] hwm;
   bit dropped;
   bit cfg_wide, cfg_comp, cfg_ns;

   req_type pending_beats [$];
   rsp_type sorted_expect [$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit drain_hold = 0;
   bit took = 0;

   // Append one command beat to the pending queue.
   function automatic void add_beat(input req_type r);
      pending_beats.insert(pending_beats.size(), r);
   endfunction

   // Update the predictor for one accepted command beat.
   task automatic predict_beat(input req_type r);
      logic [31:0] code, idx;
      int n, j;
      logic signed [15:0] ka [$], kb [$];
      logic [31:0] ix [$];
      bit bd [$];
      rsp_type e;
      logic signed [15:0] a, b;
      case (cmd_type'(r.cmd))
         CMD_LOAD_VERTEX: begin
            tab_u[r.vertex_addr] = r.vertex_u;
            tab_v[r.vertex_addr] = r.vertex_v;
         end
         CMD_PUSH_CODE: begin
            if (stored_idx.size() >= NIDX) begin
               dropped = 1;
            end else begin
               if (cfg_comp) begin
                  code = cfg_wide ? r.code_word : {16'h0, r.code_word[15:0]};
                  idx = hwm - code;
                  if (code == 0) hwm = hwm + 1;
               end else begin
                  idx = cfg_wide ? r.code_word
                                 : {{16{r.code_word[15]}}, r.code_word[15:0]};
               end
               stored_idx.insert(stored_idx.size(), idx);
            end
         end
         CMD_SORT: begin
            n = stored_idx.size();
            // Stable insertion into a sorted list of keys.
            for (int i = 0; i < n; i++) begin
               bit bad;
               bad = stored_idx[i] >= NVERT;
               a = 0;
               b = 0;
               if (!bad) begin
                  a = cfg_ns ? tab_u[stored_idx[i]] : tab_v[stored_idx[i]];
                  b = cfg_ns ? tab_v[stored_idx[i]] : tab_u[stored_idx[i]];
               end
               j = ix.size();
               while (j > 0 && (a < ka[j-1] || (a == ka[j-1] && b < kb[j-1])))
                  j--;
               ka.insert(j, a);
               kb.insert(j, b);
               ix.insert(j, stored_idx[i]);
               bd.insert(j, bad);
            end
            for (int i = 0; i < n; i++) begin
               e.sorted_index = ix[i];
               e.last = (i == n - 1);
               e.bad_index = bd[i];
               e.overflowed = dropped;
               sorted_expect.insert(sorted_expect.size(), e);
            end
            stored_idx.delete();
            hwm = 0;
            dropped = 0;
         end
         default: ;
      endcase
   endtask

   // Driver: bursts from the pending queue with random gaps.
   int gap = 0;
   int burst = 0;
   always @(negedge clock) begin
      if (!reset && !(start && !took)) begin
         if (pending_beats.size() > 0 && !drain_hold && gap == 0) begin
            req_data <= pending_beats.pop_front();
            start <= 1'b1;
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst--;
            end
         end else begin
            start <= 1'b0;
            if (gap > 0) gap--;
         end
      end
   end

   // Monitor: accepts command beats and checks result beats.
   always @(posedge clock) begin
      if (!reset) begin
         took = start && !busy;
         if (took) begin
            predict_beat(req_data);
         end
         if (took || rsp_strobe) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_strobe) begin
            if (sorted_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: %p", rsp_data);
            end else begin
               rsp_type e;
               e = sorted_expect.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Result beat differs: expected %p got %p", e, rsp_data);
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic req_type vertex_beat(input int addr);
      req_type r;
      r = '0;
      r.cmd = CMD_LOAD_VERTEX;
      r.vertex_addr = 10'(addr);
      r.vertex_u = 16'($urandom());
      r.vertex_v = ($urandom_range(0, 3) == 0) ? 16'sd5 : 16'($urandom());
      r.code_word = $urandom();
      return r;
   endfunction

   function automatic req_type code_beat(input logic [31:0] cw);
      req_type r;
      r = '0;
      r.cmd = CMD_PUSH_CODE;
      r.vertex_addr = 10'($urandom());
      r.code_word = cw;
      return r;
   endfunction

   function automatic req_type sort_beat(input cmd_type c);
      req_type r;
      r = '0;
      r.cmd = c;
      r.code_word = $urandom();
      return r;
   endfunction

   // A random code that, for the current mode, mostly decodes into the filled
   // low part of the vertex table; a few land outside the table.
   function automatic logic [31:0] pick_code(input logic [31:0] hw_now);
      int t;
      t = $urandom_range(0, 9);
      if (cfg_comp) begin
         if (t == 0) return $urandom();
         if (t < 4) return 0;
         return $urandom_range(0, (hw_now < 200) ? hw_now : 200);
      end
      // Random code forced negative, so it always falls outside the table.
      if (t == 0) return $urandom() | (cfg_wide ? 32'h8000_0000 : 32'h0000_8000);
      if (t == 1) return cfg_wide ? 32'hFFFF_FFFF : 32'h0000_8000;
      return $urandom_range(0, VFILL - 1) | ($urandom() & (cfg_wide ? 0 : 32'hFFFF_0000));
   endfunction

   // Wait for the block to drain before a register write.
   task automatic wait_idle();
      while (pending_beats.size() > 0 || sorted_expect.size() > 0 || start)
         @(posedge clock);
      drain_hold = 1;
      repeat (1000) @(posedge clock);
      drain_hold = 0;
   endtask

   task automatic write_csr(input logic [1:0] i, input bit val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= i;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (i)
         CSR_WIDE_CODES: cfg_wide = val;
         CSR_COMPRESSED_CODES: cfg_comp = val;
         default: cfg_ns = val;
      endcase
   endtask

   // Stimulus.
   initial begin
      int n;
      logic [31:0] hw_track;
      logic [31:0] dir_codes [8];
      dir_codes = '{32'h0, 32'h3FF, 32'h400, 32'h7FFF,
                    32'h8000, 32'hFFFF, 32'h1_0005, 32'hFFFF_FFFF};
      hwm = 0;
      dropped = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Fill the low part of the vertex table; every generated index lands
      // there, on the top entry, or outside the table.
      for (int a = 0; a < VFILL; a++) add_beat(vertex_beat(a));
      // Directed: extremes of coordinates and codes, empty sort, unused command.
      begin
         req_type r;
         r = vertex_beat(0); r.vertex_u = 16'sh8000; r.vertex_v = 16'sh7FFF;
         add_beat(r);
         r = vertex_beat(1023); r.vertex_u = 16'sh7FFF; r.vertex_v = 16'sh8000;
         add_beat(r);
      end
      add_beat(sort_beat(CMD_SORT));
      add_beat(sort_beat(CMD_NONE));
      for (int k = 0; k < 8; k++)
         add_beat(code_beat(dir_codes[k]));
      add_beat(code_beat(1023));
      add_beat(sort_beat(CMD_SORT));
      add_beat(sort_beat(CMD_SORT));
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_WIDE_CODES, ph[0]);
         write_csr(CSR_COMPRESSED_CODES, ph[1]);
         write_csr(CSR_NORTH_SOUTH_ORDER, ph[2]);
         for (int run = 0; run < 3; run++) begin
            // Mostly short runs; two phases end with a full run that overflows.
            n = (run == 2 && (ph == 1 || ph == 6)) ? NIDX + $urandom_range(1, 3)
                                                   : $urandom_range(1, 8);
            hw_track = 0;
            for (int k = 0; k < n; k++) begin
               logic [31:0] cw;
               cw = pick_code(hw_track);
               if (cfg_comp && (cfg_wide ? cw : {16'h0, cw[15:0]}) == 0)
                  hw_track++;
               add_beat(code_beat(cw));
               if ($urandom_range(0, 7) == 0)
                  add_beat(vertex_beat($urandom_range(0, NVERT - 1)));
               if ($urandom_range(0, 15) == 0)
                  add_beat(sort_beat(CMD_NONE));
            end
            add_beat(sort_beat(CMD_SORT));
         end
         wait_idle();
      end
      while (sorted_expect.size() > 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (mismatches == 0 && sorted_expect.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
